@@ sv/lfr_pkg.sv @@
package lfr_pkg;

  localparam int TABLE_DEPTH   = 55;
  localparam int WORD_BITS     = 30;
  localparam int SHORT_LAG     = 24;
  localparam int DRAW_SHIFT    = 6;
  localparam int DRAW_BITS     = WORD_BITS - DRAW_SHIFT;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int PARTNER_START = TABLE_DEPTH - SHORT_LAG;
  localparam int SEED_W        = 30;
  localparam int VAL_W         = 31;
  localparam int ACT_W         = 2;
  localparam int BW_W          = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_RESEED = 2'd0,
    ACT_RAW    = 2'd1,
    ACT_RANGE  = 2'd2,
    ACT_BITS   = 2'd3
  } act_t;

  typedef struct packed {
    logic cap;
    logic fill_init;
    logic fill_step;
    logic rd;
    logic wr;
    logic out_load;
  } lfr_cmd_t;

  typedef struct packed {
    act_t in_action;
    logic in_trivial;
    act_t action;
    logic trivial;
    logic num_ok;
    logic fill_last;
  } lfr_stat_t;

endpackage

@@ sv/lfr_channels.sv @@
interface lfr_req_if;
  import lfr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [VAL_W-1:0] range_low;
  logic signed [VAL_W-1:0] range_high;
  logic [BW_W-1:0]         bit_width;
  modport source (output valid, action, range_low, range_high, bit_width, input ready);
  modport sink (input valid, action, range_low, range_high, bit_width, output ready);
endinterface

interface lfr_rsp_if;
  import lfr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

interface lfr_cfg_if;
  import lfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [SEED_W-1:0] seed;
  modport source (output valid, seed, input ready);
  modport sink (input valid, seed, output ready);
endinterface

@@ sv/lagged_fibonacci_range_rng.sv @@
// Raw and bits items pass through the table read, add and write back states (READ, SUM)
// to FINISH, where the result is loaded once the output slot is free; only then is the
// next item accepted. A range item repeats that draw loop for each rejected draw; a range
// that needs no draw goes straight to FINISH; a reseed gives its result after refilling the table.
// After reset the block fills its table from seed 0 and takes no item while it fills;
// configuration writes are taken at any time.
module lagged_fibonacci_range_rng (
  input logic    clk,
  input logic    rst,
  lfr_cfg_if.sink  cfg,
  lfr_req_if.sink  req,
  lfr_rsp_if.source rsp
);
  import lfr_pkg::*;

  lfr_cmd_t  cmd;
  lfr_stat_t stat;

  assign cfg.ready = 1'b1;

  lfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfr_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .seed_we    (cfg.valid),
    .seed_in    (cfg.seed),
    .action     (req.action),
    .range_low  (req.range_low),
    .range_high (req.range_high),
    .bit_width  (req.bit_width),
    .value      (rsp.value)
  );

endmodule

@@ sv/lfr_ctrl.sv @@
module lfr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lfr_pkg::lfr_stat_t stat,
  output lfr_pkg::lfr_cmd_t  cmd
);
  import lfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_SUM,
    S_FINISH
  } state_t;

  state_t state;
  logic   reply;
  logic   slot_free;
  logic   retry;

  assign slot_free = !out_valid || out_ready;
  assign retry     = (stat.action == ACT_RANGE) && !stat.trivial && !stat.num_ok;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.cap       = (state == S_IDLE) && in_valid;
    cmd.fill_init = cmd.cap && (stat.in_action == ACT_RESEED);
    cmd.fill_step = (state == S_FILL);
    cmd.rd        = (state == S_READ);
    cmd.wr        = (state == S_SUM);
    cmd.out_load  = (state == S_FINISH) && !retry && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      reply     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (stat.in_action)
              ACT_RESEED: begin
                state <= S_FILL;
                reply <= 1'b1;
              end
              ACT_RANGE: state <= stat.in_trivial ? S_FINISH : S_READ;
              default:   state <= S_READ;
            endcase
          end
        end
        S_FILL: begin
          if (stat.fill_last) begin
            state <= reply ? S_FINISH : S_IDLE;
            reply <= 1'b0;
          end
        end
        S_READ: state <= S_SUM;
        S_SUM:  state <= S_FINISH;
        S_FINISH: begin
          if (retry) begin
            state <= S_READ;
          end else if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting item");

  a_read_write: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> cmd.wr)
    else $error("table read not followed by its write back");

  a_no_accept_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |=> (!in_ready || !cmd.fill_step))
    else $error("item accepted while the table is being filled");

endmodule

@@ sv/lfr_dpath.sv @@
module lfr_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  lfr_pkg::lfr_cmd_t                cmd,
  output lfr_pkg::lfr_stat_t               stat,
  input  logic                             seed_we,
  input  logic [lfr_pkg::SEED_W-1:0]       seed_in,
  input  logic [lfr_pkg::ACT_W-1:0]        action,
  input  logic signed [lfr_pkg::VAL_W-1:0] range_low,
  input  logic signed [lfr_pkg::VAL_W-1:0] range_high,
  input  logic [lfr_pkg::BW_W-1:0]         bit_width,
  output logic signed [lfr_pkg::VAL_W-1:0] value
);
  import lfr_pkg::*;

  function automatic logic [VAL_W-1:0] smear(input logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] m;
    m = x;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

  logic [WORD_BITS-1:0] lag_table [TABLE_DEPTH];

  logic [SEED_W-1:0]    seed;
  logic                 use_seed;
  logic [IDX_W-1:0]     fill_idx;
  logic [WORD_BITS-1:0] fill_a;
  logic [WORD_BITS-1:0] fill_b;
  logic [WORD_BITS-1:0] fill_wdata;
  logic [IDX_W-1:0]     wi;
  logic [IDX_W-1:0]     pi;
  logic [WORD_BITS-1:0] rd_w;
  logic [WORD_BITS-1:0] rd_p;
  logic [WORD_BITS-1:0] sum;
  logic [DRAW_BITS-1:0] draw_val;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  act_t                 act_r;
  logic [VAL_W-1:0]     lo_r;
  logic [VAL_W-1:0]     span_m1_r;
  logic [VAL_W-1:0]     mask_r;
  logic                 trivial_r;
  logic [BW_W-1:0]      bw_r;

  logic [VAL_W:0]       in_span_m1;
  logic                 in_trivial;
  logic [VAL_W-1:0]     range_num;
  logic [DRAW_BITS-1:0] bits_mask;
  logic [VAL_W-1:0]     result;

  assign in_span_m1 = {range_high[VAL_W-1], range_high} - {range_low[VAL_W-1], range_low};
  assign in_trivial = in_span_m1[VAL_W] || (in_span_m1 == '0) ||
                      ((range_low == '0) && (range_high == '0));

  always_comb begin
    if (fill_idx == '0) begin
      fill_wdata = use_seed ? WORD_BITS'(seed) : '0;
    end else if (fill_idx == IDX_W'(1)) begin
      fill_wdata = WORD_BITS'(1);
    end else begin
      fill_wdata = fill_a + fill_b;
    end
  end

  assign sum       = rd_w + rd_p;
  assign mem_we    = cmd.fill_step || cmd.wr;
  assign mem_waddr = cmd.fill_step ? fill_idx : wi;
  assign mem_wdata = cmd.fill_step ? fill_wdata : sum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lag_table[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_w <= lag_table[wi];
      rd_p <= lag_table[pi];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed     <= '0;
      use_seed <= 1'b0;
      fill_idx <= '0;
      wi       <= '0;
      pi       <= IDX_W'(PARTNER_START);
    end else begin
      if (seed_we) begin
        seed <= seed_in;
      end
      if (cmd.fill_init) begin
        use_seed <= 1'b1;
        fill_idx <= '0;
        wi       <= '0;
        pi       <= IDX_W'(PARTNER_START);
      end else if (cmd.fill_step) begin
        fill_idx <= (fill_idx == IDX_W'(TABLE_DEPTH - 1)) ? '0 : fill_idx + 1'b1;
      end else if (cmd.wr) begin
        wi <= (wi == IDX_W'(TABLE_DEPTH - 1)) ? '0 : wi + 1'b1;
        pi <= (pi == IDX_W'(TABLE_DEPTH - 1)) ? '0 : pi + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      fill_a <= fill_b;
      fill_b <= fill_wdata;
    end
    if (cmd.wr) begin
      draw_val <= sum[WORD_BITS-1:DRAW_SHIFT];
    end
    if (cmd.cap) begin
      act_r     <= act_t'(action);
      lo_r      <= range_low;
      span_m1_r <= in_span_m1[VAL_W-1:0];
      mask_r    <= smear(in_span_m1[VAL_W-1:0]);
      trivial_r <= in_trivial;
      bw_r      <= bit_width;
    end
    if (cmd.out_load) begin
      value <= result;
    end
  end

  assign range_num = VAL_W'(draw_val) & mask_r;
  assign bits_mask = (int'(bw_r) >= DRAW_BITS) ? '1 : ((DRAW_BITS'(1) << bw_r) - 1'b1);

  always_comb begin
    case (act_r)
      ACT_RESEED: result = '0;
      ACT_RAW:    result = VAL_W'(draw_val);
      ACT_RANGE:  result = trivial_r ? lo_r : lo_r + range_num;
      ACT_BITS:   result = VAL_W'(draw_val & bits_mask);
      default:    result = '0;
    endcase
  end

  always_comb begin
    stat            = '0;
    stat.in_action  = act_t'(action);
    stat.in_trivial = in_trivial;
    stat.action     = act_r;
    stat.trivial    = trivial_r;
    stat.num_ok     = (range_num <= span_m1_r);
    stat.fill_last  = (fill_idx == IDX_W'(TABLE_DEPTH - 1));
  end

  a_lag_spacing: assert property (@(posedge clk) disable iff (rst)
    (pi > wi) ? ((pi - wi) == IDX_W'(PARTNER_START)) : ((wi - pi) == IDX_W'(SHORT_LAG)))
    else $error("write and partner indices lost their lag spacing");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (int'(wi) < TABLE_DEPTH) && (int'(fill_idx) < TABLE_DEPTH))
    else $error("table index beyond the table depth");

endmodule

@@ tb/lagged_fibonacci_range_rng_test.sv @@
module lagged_fibonacci_range_rng_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfr_pkg::*;

  localparam int IDLE_PCT     = 27;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 88;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 64;
  localparam int MAX_PRINTS   = 100;

  localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [SEED_W-1:0] SEED_MAX = '1;

  typedef struct {
    act_t                    action;
    logic signed [VAL_W-1:0] range_low;
    logic signed [VAL_W-1:0] range_high;
    logic [BW_W-1:0]         bit_width;
    bit                      known;
    logic signed [VAL_W-1:0] value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lfr_cfg_if cfg_ch ();
  lfr_req_if req_ch ();
  lfr_rsp_if rsp_ch ();

  lagged_fibonacci_range_rng u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [WORD_BITS-1:0] lag_words [TABLE_DEPTH];
  int unsigned          wr_pos;
  int unsigned          pt_pos;
  logic [SEED_W-1:0]    seed_copy;

  logic [VAL_W-1:0] expected_values [$];
  int               error_count = 0;
  bit               req_idle_on = 1'b1;
  bit               rsp_idle_on = 1'b1;

  stim_row_t dir_table [23] = '{
    '{ACT_RAW,    '0,          '0,          5'd0,  1'b0, '0},
    '{ACT_BITS,   '0,          '0,          5'd0,  1'b1, '0},
    '{ACT_BITS,   '0,          '0,          5'd30, 1'b0, '0},
    '{ACT_BITS,   '0,          '0,          5'd24, 1'b0, '0},
    '{ACT_BITS,   '0,          '0,          5'd23, 1'b0, '0},
    '{ACT_BITS,   '0,          '0,          5'd1,  1'b0, '0},
    '{ACT_RANGE,  '0,          '0,          5'd0,  1'b1, '0},
    '{ACT_RANGE,  31'sd7,      31'sd7,      5'd0,  1'b1, 31'sd7},
    '{ACT_RANGE,  31'sd100,    31'sd3,      5'd0,  1'b1, 31'sd100},
    '{ACT_RANGE,  VMIN,        VMIN,        5'd0,  1'b1, VMIN},
    '{ACT_RANGE,  VMAX,        VMIN,        5'd0,  1'b1, VMAX},
    '{ACT_RANGE,  31'sd0,      -31'sd5,     5'd0,  1'b1, 31'sd0},
    '{ACT_RANGE,  VMIN,        VMAX,        5'd0,  1'b0, '0},
    '{ACT_RANGE,  31'sd0,      31'sd1,      5'd0,  1'b0, '0},
    '{ACT_RANGE,  31'sd1,      31'sd100,    5'd0,  1'b0, '0},
    '{ACT_RANGE,  31'sd0,      31'sd5,      5'd0,  1'b0, '0},
    '{ACT_RANGE,  -31'sd10,    -31'sd8,     5'd0,  1'b0, '0},
    '{ACT_RANGE,  31'sd0,      31'sd16777216, 5'd0, 1'b0, '0},
    '{ACT_RANGE,  31'sd0,      31'sd8,      5'd0,  1'b0, '0},
    '{ACT_RESEED, '0,          '0,          5'd0,  1'b1, '0},
    '{ACT_RAW,    '0,          '0,          5'd0,  1'b0, '0},
    '{ACT_RANGE,  VMAX,        VMAX,        5'd0,  1'b1, VMAX},
    '{ACT_BITS,   VMIN,        VMAX,        5'd16, 1'b0, '0}
  };

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("%0t ERROR: %s", $time, msg);
  endtask

  function automatic void refill_table();
    lag_words[0] = seed_copy;
    lag_words[1] = WORD_BITS'(1);
    for (int i = 2; i < TABLE_DEPTH; i++) lag_words[i] = lag_words[i-1] + lag_words[i-2];
    wr_pos = 0;
    pt_pos = PARTNER_START;
  endfunction

  function automatic logic [DRAW_BITS-1:0] draw_word();
    logic [WORD_BITS-1:0] sum;
    sum = lag_words[wr_pos] + lag_words[pt_pos];
    lag_words[wr_pos] = sum;
    wr_pos = (wr_pos + 1 == TABLE_DEPTH) ? 0 : wr_pos + 1;
    pt_pos = (pt_pos + 1 == TABLE_DEPTH) ? 0 : pt_pos + 1;
    return sum[WORD_BITS-1:DRAW_SHIFT];
  endfunction

  function automatic logic [VAL_W-1:0] predict_value(stim_row_t it);
    longint           lo;
    longint           hi;
    longint           span;
    longint           power;
    longint           num;
    logic [VAL_W-1:0] res;
    res = '0;
    case (it.action)
      ACT_RESEED: refill_table();
      ACT_RAW: res = VAL_W'(draw_word());
      ACT_RANGE: begin
        lo = it.range_low;
        hi = it.range_high;
        if (lo != 0 || hi != 0) begin
          span = hi - lo + 1;
          if (span <= 1) begin
            res = VAL_W'(lo);
          end else begin
            power = 2;
            while (power < span) power = power << 1;
            do begin
              num = longint'(draw_word()) & (power - 1);
            end while (num >= span);
            res = VAL_W'(lo + num);
          end
        end
      end
      ACT_BITS: res = VAL_W'(longint'(draw_word()) & ((longint'(1) << it.bit_width) - 1));
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic stim_row_t random_item();
    stim_row_t it;
    int        pick;
    int        k;
    int        delta;
    longint    lo;
    longint    span;
    it.action     = ACT_RAW;
    it.range_low  = VAL_W'($urandom);
    it.range_high = VAL_W'($urandom);
    it.bit_width  = BW_W'($urandom_range(0, 30));
    it.known      = 1'b0;
    it.value      = '0;
    pick = $urandom_range(99);
    if (pick < 4) begin
      it.action = ACT_RESEED;
    end else if (pick < 28) begin
      it.action = ACT_RAW;
    end else if (pick < 52) begin
      it.action = ACT_BITS;
    end else begin
      it.action = ACT_RANGE;
      case ($urandom_range(9))
        0: begin
          it.range_low  = '0;
          it.range_high = '0;
        end
        1: it.range_high = it.range_low;
        2: ;
        3: begin
          if ($urandom_range(1) == 1) it.range_low = VMIN;
          it.range_high = VMAX;
        end
        7, 8: begin
          k     = $urandom_range(1, 26);
          delta = $urandom_range(0, 2);
          span  = (longint'(1) << k) + delta - 1;
          lo    = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
          it.range_low  = VAL_W'(lo);
          it.range_high = VAL_W'(lo + span - 1);
        end
        9: it.range_high = it.range_low + VAL_W'($urandom_range(0, 64));
        default: begin
          lo   = longint'($urandom_range(0, 2000)) - 1000;
          span = $urandom_range(2, 300);
          it.range_low  = VAL_W'(lo);
          it.range_high = VAL_W'(lo + span - 1);
        end
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input stim_row_t it);
    logic [VAL_W-1:0] predicted;
    if (req_idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= it.action;
    req_ch.range_low  <= it.range_low;
    req_ch.range_high <= it.range_high;
    req_ch.bit_width  <= it.bit_width;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_value(it);
    expected_values.push_back(it.known ? it.value : predicted);
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [SEED_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    seed_copy = v;
  endtask

  always @(posedge clk) begin : check_results
    logic [VAL_W-1:0] want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", $signed(rsp_ch.value)));
      end else begin
        want = expected_values.pop_front();
        if (rsp_ch.value !== want)
          report_mismatch($sformatf("value %0d, expected %0d",
                                    $signed(rsp_ch.value), $signed(want)));
      end
    end
  end

  initial begin : result_sink
    int accepted;
    bit held;
    accepted = 0;
    held     = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      if (!held && accepted >= HOLD_AT) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= !rsp_idle_on || ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) accepted++;
    end
  end

  initial begin
    #20000000;
    $display("lagged_fibonacci_range_rng_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [SEED_W-1:0] seed_val;
    stim_row_t         row;
    int                waited;
    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_RAW;
    req_ch.range_low  = '0;
    req_ch.range_high = '0;
    req_ch.bit_width  = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.seed       = '0;
    seed_copy = '0;
    refill_table();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_seed('0);

    foreach (dir_table[i]) send_item(dir_table[i]);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_all_results();
      case (phase)
        0: seed_val = SEED_MAX;
        1: seed_val = '0;
        2: seed_val = 30'd1;
        4: seed_val = 30'h2AAAAAAA;
        default: seed_val = SEED_W'($urandom);
      endcase
      req_idle_on = (phase != 3);
      rsp_idle_on = (phase != 3);
      write_seed(seed_val);
      row = random_item();
      row.action = ACT_RESEED;
      send_item(row);
      for (int n = 1; n < PHASE_ITEMS; n++) send_item(random_item());
    end

    req_ch.valid <= 1'b0;
    waited = 0;
    while (expected_values.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_values.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_values.size()));
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("lagged_fibonacci_range_rng_test: done, clean");
    else
      $display("lagged_fibonacci_range_rng_test: done, errors");
    $finish;
  end

endmodule
